// ===== hdl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, codes and defaults for the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int unsigned MAX_HOLES_DEF  = 64;
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF  = 16;

  localparam int unsigned FIELD_W = 16;

  localparam logic [15:0] CAP_RESET    = 16'd2100;
  localparam logic [1:0]  POLICY_RESET = 2'd1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_POLICY   = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [FIELD_W-1:0]   request_size;
    logic [FIELD_W-1:0]   block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FIELD_W-1:0]   granted_address;
  } rsp_t;

  typedef struct packed {
    logic        cap_wr;
    logic [31:0] capacity;
    logic [1:0]  policy;
  } cfg_t;

endpackage

// ===== hdl/contiguous_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_unit
// Contiguous region allocator with first/best/worst fit and hole merging.
// ----------------------------------------------------------------------------
// Sequence: allocate scans every hole, then updates the picked hole; free scans
//   every block slot, then every hole, then merges. Dropping a used-up hole or a
//   merged right hole pulls later entries down; a new front hole pushes entries up.
// Throughput: one request at a time, paced by one memory read per cycle while scanning.
// Reset: the init state writes the initial hole with busy high; each result shows
//   for one cycle on valid_o and the receiver cannot stall.
module contiguous_fit_allocator_unit #(
  parameter int unsigned MAX_HOLES  = cfa_pkg::MAX_HOLES_DEF,
  parameter int unsigned MAX_BLOCKS = cfa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = cfa_pkg::ADDR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // request channel
  input  logic          start,
  output logic          busy,
  input  cfa_pkg::req_t req_i,
  // result channel
  output logic          valid_o,
  output cfa_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = ADDR_BITS;
  // capacity field is 16 bits wide, masked further to the address width
  localparam int unsigned CW = (AW < cfa_pkg::FIELD_W) ? AW : cfa_pkg::FIELD_W;

  logic [AW-1:0] capacity_q, capacity_d;
  logic [1:0]    policy_q, policy_d;
  logic          wr_en;
  logic          reg_idx;
  cfa_pkg::cfg_t cfg;

  // decode the register index from the word address
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    policy_d   = policy_q;
    if (wr_en) begin
      case (reg_idx)
        cfa_pkg::REG_CAPACITY: capacity_d = AW'(pwdata[CW-1:0]);
        cfa_pkg::REG_POLICY:   policy_d   = pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= AW'(cfa_pkg::CAP_RESET);
      policy_q   <= cfa_pkg::POLICY_RESET;
    end else begin
      capacity_q <= capacity_d;
      policy_q   <= policy_d;
    end
  end

  // read back the register selected by the address
  always_comb begin
    case (reg_idx)
      cfa_pkg::REG_CAPACITY: prdata = 32'(capacity_q);
      cfa_pkg::REG_POLICY:   prdata = 32'(policy_q);
      default:               prdata = '0;
    endcase
  end

  // a capacity write rebuilds both tables when the core is idle; the core sees the new value
  assign cfg.cap_wr   = wr_en && (reg_idx == cfa_pkg::REG_CAPACITY);
  assign cfg.capacity = 32'(capacity_d);
  assign cfg.policy   = policy_q;

  cfa_core #(
    .MAX_HOLES (MAX_HOLES),
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .start_i(start),
    .busy_o (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== hdl/cfa_ram.sv =====
// ----------------------------------------------------------------------------
// cfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cfa_core.sv =====
// ----------------------------------------------------------------------------
// cfa_core
// Sequencer over the hole and block memories: scan, update, compact.
// ----------------------------------------------------------------------------
module cfa_core #(
  parameter int unsigned MAX_HOLES  = cfa_pkg::MAX_HOLES_DEF,
  parameter int unsigned MAX_BLOCKS = cfa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = cfa_pkg::ADDR_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfa_pkg::cfg_t cfg_i,
  input  logic          start_i,
  output logic          busy_o,
  input  cfa_pkg::req_t req_i,
  output logic          valid_o,
  output cfa_pkg::rsp_t rsp_o
);

  localparam int unsigned AW  = ADDR_BITS;
  localparam int unsigned IW  = $clog2(MAX_HOLES);
  localparam int unsigned IW1 = $clog2(MAX_HOLES + 1);
  localparam int unsigned BW  = $clog2(MAX_BLOCKS);
  localparam int unsigned BW1 = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned WW  = ((AW > cfa_pkg::FIELD_W) ? AW : cfa_pkg::FIELD_W) + 1;
  localparam int unsigned FW  = cfa_pkg::FIELD_W;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_AUPD  = 4'd3;
  localparam logic [3:0] S_BSCAN = 4'd4;
  localparam logic [3:0] S_HSCAN = 4'd5;
  localparam logic [3:0] S_FUPD  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DWR   = 4'd8;
  localparam logic [3:0] S_URD   = 4'd9;
  localparam logic [3:0] S_UWR   = 4'd10;
  localparam logic [3:0] S_UFIN  = 4'd11;

  logic [3:0]            state_q, state_d;
  logic [IW1-1:0]        count_q, count_d;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  cfa_pkg::req_t         req_q, req_d;
  logic                  valid_q, valid_d;
  cfa_pkg::rsp_t         rsp_q, rsp_d;
  logic [FW-1:0]         gr_q, gr_d;

  logic [IW1-1:0] hsc_q, hsc_d;
  logic           hpend_q, hpend_d;
  logic [IW-1:0]  hpidx_q, hpidx_d;
  logic [BW1-1:0] bsc_q, bsc_d;
  logic           bpend_q, bpend_d;
  logic [BW-1:0]  bpidx_q, bpidx_d;

  logic           have_q, have_d;
  logic [IW-1:0]  pick_q, pick_d;
  logic [AW-1:0]  pb_q, pb_d, pl_q, pl_d;

  logic           found_q, found_d;
  logic [BW-1:0]  slot_q, slot_d;
  logic [AW-1:0]  blen_q, blen_d;
  logic           hasl_q, hasl_d, hasr_q, hasr_d;
  logic [IW-1:0]  li_q, li_d, ri_q, ri_d;
  logic [AW-1:0]  lb_q, lb_d, ll_q, ll_d, rl_q, rl_d;

  logic [IW1-1:0] mv_q, mv_d;

  logic            h_we;
  logic [IW-1:0]   h_waddr, h_raddr;
  logic [2*AW-1:0] h_wdata, h_rdata;
  logic            b_we;
  logic [BW-1:0]   b_waddr, b_raddr;
  logic [2*AW-1:0] b_wdata, b_rdata;

  logic [AW-1:0] hr_begin, hr_len, br_begin, br_len;
  assign hr_begin = h_rdata[2*AW-1:AW];
  assign hr_len   = h_rdata[AW-1:0];
  assign br_begin = b_rdata[2*AW-1:AW];
  assign br_len   = b_rdata[AW-1:0];

  cfa_ram #(.WIDTH(2*AW), .DEPTH(MAX_HOLES)) u_hole_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  cfa_ram #(.WIDTH(2*AW), .DEPTH(MAX_BLOCKS)) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  // lowest free allocation slot
  logic          free_ok;
  logic [BW-1:0] free_slot;
  always_comb begin
    free_ok   = 1'b0;
    free_slot = '0;
    for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
      if (!used_q[k]) begin
        free_ok   = 1'b1;
        free_slot = BW'(k);
      end
    end
  end

  logic          fits;
  logic [AW-1:0] size_aw, addr_aw, newlen;
  assign size_aw = AW'(req_q.request_size);
  assign addr_aw = AW'(req_q.block_address);
  assign fits    = WW'(hr_len) >= WW'(req_q.request_size);
  assign newlen  = pl_q - size_aw;

  logic is_left, is_right;
  assign is_left  = (WW'(hr_begin) + WW'(hr_len)) == WW'(req_q.block_address);
  assign is_right = WW'(hr_begin) == (WW'(req_q.block_address) + WW'(blen_q));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    used_d  = used_q;
    req_d   = req_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    gr_d    = gr_q;
    hsc_d   = hsc_q;
    hpend_d = 1'b0;
    hpidx_d = hpidx_q;
    bsc_d   = bsc_q;
    bpend_d = 1'b0;
    bpidx_d = bpidx_q;
    have_d  = have_q;
    pick_d  = pick_q;
    pb_d    = pb_q;
    pl_d    = pl_q;
    found_d = found_q;
    slot_d  = slot_q;
    blen_d  = blen_q;
    hasl_d  = hasl_q;
    hasr_d  = hasr_q;
    li_d    = li_q;
    ri_d    = ri_q;
    lb_d    = lb_q;
    ll_d    = ll_q;
    rl_d    = rl_q;
    mv_d    = mv_q;
    h_we    = 1'b0;
    h_waddr = '0;
    h_wdata = '0;
    h_raddr = hsc_q[IW-1:0];
    b_we    = 1'b0;
    b_waddr = free_slot;
    b_wdata = {pb_q, size_aw};
    b_raddr = bsc_q[BW-1:0];

    case (state_q)
      S_INIT: begin
        h_we    = 1'b1;
        h_wdata = {{AW{1'b0}}, AW'(cfg_i.capacity)};
        count_d = (AW'(cfg_i.capacity) != '0) ? IW1'(1) : '0;
        used_d  = '0;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_i.cap_wr) begin
          h_we    = 1'b1;
          h_wdata = {{AW{1'b0}}, AW'(cfg_i.capacity)};
          count_d = (AW'(cfg_i.capacity) != '0) ? IW1'(1) : '0;
          used_d  = '0;
        end else if (start_i) begin
          req_d   = req_i;
          gr_d    = '0;
          hsc_d   = '0;
          bsc_d   = '0;
          have_d  = 1'b0;
          found_d = 1'b0;
          hasl_d  = 1'b0;
          hasr_d  = 1'b0;
          state_d = (req_i.operation == cfa_pkg::OP_FREE) ? S_BSCAN : S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (hsc_q < count_q) begin
          hpend_d = 1'b1;
          hpidx_d = hsc_q[IW-1:0];
          hsc_d   = hsc_q + IW1'(1);
        end
        if (hpend_q && fits) begin
          if (!have_q ||
              (cfg_i.policy == cfa_pkg::POL_BEST && hr_len < pl_q) ||
              (cfg_i.policy == cfa_pkg::POL_WORST && hr_len > pl_q)) begin
            have_d = 1'b1;
            pick_d = hpidx_q;
            pb_d   = hr_begin;
            pl_d   = hr_len;
          end
        end
        if (!(hsc_q < count_q) && !hpend_q) begin
          state_d = S_AUPD;
        end
      end
      S_AUPD: begin
        state_d = S_IDLE;
        valid_d = 1'b1;
        rsp_d   = '{status: cfa_pkg::ST_OK, granted_address: '0};
        if (req_q.request_size == '0 || !have_q) begin
          rsp_d.status = cfa_pkg::ST_NOFIT;
        end else if (!free_ok) begin
          rsp_d.status = cfa_pkg::ST_FULL;
        end else begin
          b_we                = 1'b1;
          used_d[free_slot]   = 1'b1;
          rsp_d.granted_address = FW'(pb_q);
          gr_d                = FW'(pb_q);
          if (newlen != '0) begin
            h_we    = 1'b1;
            h_waddr = pick_q;
            h_wdata = {pb_q + size_aw, newlen};
          end else begin
            valid_d = 1'b0;
            mv_d    = IW1'(pick_q);
            state_d = S_DRD;
          end
        end
      end
      S_BSCAN: begin
        if (bsc_q != BW1'(MAX_BLOCKS)) begin
          bpend_d = 1'b1;
          bpidx_d = bsc_q[BW-1:0];
          bsc_d   = bsc_q + BW1'(1);
        end
        if (bpend_q && !found_q && used_q[bpidx_q] &&
            WW'(br_begin) == WW'(req_q.block_address)) begin
          found_d = 1'b1;
          slot_d  = bpidx_q;
          blen_d  = br_len;
        end
        if (bsc_q == BW1'(MAX_BLOCKS) && !bpend_q) begin
          if (found_q) begin
            state_d = S_HSCAN;
          end else begin
            state_d = S_IDLE;
            valid_d = 1'b1;
            rsp_d   = '{status: cfa_pkg::ST_UNKNOWN, granted_address: '0};
          end
        end
      end
      S_HSCAN: begin
        if (hsc_q < count_q) begin
          hpend_d = 1'b1;
          hpidx_d = hsc_q[IW-1:0];
          hsc_d   = hsc_q + IW1'(1);
        end
        if (hpend_q) begin
          if (!hasl_q && is_left) begin
            hasl_d = 1'b1;
            li_d   = hpidx_q;
            lb_d   = hr_begin;
            ll_d   = hr_len;
          end
          if (!hasr_q && is_right) begin
            hasr_d = 1'b1;
            ri_d   = hpidx_q;
            rl_d   = hr_len;
          end
        end
        if (!(hsc_q < count_q) && !hpend_q) begin
          state_d = S_FUPD;
        end
      end
      S_FUPD: begin
        state_d = S_IDLE;
        valid_d = 1'b1;
        rsp_d   = '{status: cfa_pkg::ST_OK, granted_address: '0};
        if (hasl_q && hasr_q) begin
          h_we           = 1'b1;
          h_waddr        = li_q;
          h_wdata        = {lb_q, ll_q + blen_q + rl_q};
          used_d[slot_q] = 1'b0;
          valid_d        = 1'b0;
          mv_d           = IW1'(ri_q);
          state_d        = S_DRD;
        end else if (hasl_q) begin
          h_we           = 1'b1;
          h_waddr        = li_q;
          h_wdata        = {lb_q, ll_q + blen_q};
          used_d[slot_q] = 1'b0;
        end else if (hasr_q) begin
          h_we           = 1'b1;
          h_waddr        = ri_q;
          h_wdata        = {addr_aw, rl_q + blen_q};
          used_d[slot_q] = 1'b0;
        end else if (count_q == IW1'(MAX_HOLES)) begin
          rsp_d.status = cfa_pkg::ST_FULL;
        end else begin
          used_d[slot_q] = 1'b0;
          valid_d        = 1'b0;
          mv_d           = count_q;
          state_d        = S_URD;
        end
      end
      S_DRD: begin
        // pull the next entry down over the dropped one
        if ((mv_q + IW1'(1)) < count_q) begin
          h_raddr = IW'(mv_q + IW1'(1));
          state_d = S_DWR;
        end else begin
          count_d = count_q - IW1'(1);
          state_d = S_IDLE;
          valid_d = 1'b1;
          rsp_d   = '{status: cfa_pkg::ST_OK, granted_address: gr_q};
        end
      end
      S_DWR: begin
        h_we    = 1'b1;
        h_waddr = mv_q[IW-1:0];
        h_wdata = h_rdata;
        mv_d    = mv_q + IW1'(1);
        state_d = S_DRD;
      end
      S_URD: begin
        // push entries up by one to open the front slot
        if (mv_q != '0) begin
          h_raddr = IW'(mv_q - IW1'(1));
          state_d = S_UWR;
        end else begin
          state_d = S_UFIN;
        end
      end
      S_UWR: begin
        h_we    = 1'b1;
        h_waddr = mv_q[IW-1:0];
        h_wdata = h_rdata;
        mv_d    = mv_q - IW1'(1);
        state_d = S_URD;
      end
      S_UFIN: begin
        h_we    = 1'b1;
        h_waddr = '0;
        h_wdata = {addr_aw, blen_q};
        count_d = count_q + IW1'(1);
        state_d = S_IDLE;
        valid_d = 1'b1;
        rsp_d   = '{status: cfa_pkg::ST_OK, granted_address: '0};
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      count_q <= '0;
      used_q  <= '0;
      valid_q <= 1'b0;
      hpend_q <= 1'b0;
      bpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      used_q  <= used_d;
      valid_q <= valid_d;
      hpend_q <= hpend_d;
      bpend_q <= bpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    rsp_q   <= rsp_d;
    gr_q    <= gr_d;
    hsc_q   <= hsc_d;
    hpidx_q <= hpidx_d;
    bsc_q   <= bsc_d;
    bpidx_q <= bpidx_d;
    have_q  <= have_d;
    pick_q  <= pick_d;
    pb_q    <= pb_d;
    pl_q    <= pl_d;
    found_q <= found_d;
    slot_q  <= slot_d;
    blen_q  <= blen_d;
    hasl_q  <= hasl_d;
    hasr_q  <= hasr_d;
    li_q    <= li_d;
    ri_q    <= ri_d;
    lb_q    <= lb_d;
    ll_q    <= ll_d;
    rl_q    <= rl_d;
    mv_q    <= mv_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IW1'(MAX_HOLES))
    else $error("hole count above table depth");

  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe longer than one cycle");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && rsp_q.status != cfa_pkg::ST_OK |-> rsp_q.granted_address == '0)
    else $error("grant nonzero on failed request");

  a_scan_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN || state_q == S_HSCAN || state_q == S_BSCAN) |-> !h_we && !b_we)
    else $error("table written during scan");

endmodule
